>>> hdl/mmab_pkg.sv
// Shared types and constants for the min/max adaptive binarizer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package mmab_pkg;

  // Frame store capacity in pixels.
  localparam int MAX_PIXELS_DEF = 32768;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Input word kinds.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // Reciprocal of five, scaled by 2^10; exact for sums below 1024.
  localparam int DIV5_MUL   = 205;
  localparam int DIV5_SHIFT = 10;

  // Operations carried out by the back end.
  typedef enum logic {
    OP_WRITE,
    OP_READ
  } op_t;

  // Command word without its address: pixel data on a write,
  // frame threshold on a read.
  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic       last_mark;
  } cmd_t;

endpackage

`default_nettype wire

>>> hdl/mmab_fifo.sv
// Short command queue between the front and back ends of the binarizer.
// Depends on mmab_pkg for the default queue depth.
`default_nettype none

module mmab_fifo
  import mmab_pkg::*;
#(
  parameter int W     = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_word,
  input  wire logic         pop,
  output logic              full,
  output logic              not_empty,
  output logic [W-1:0]      head_word
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [W-1:0]  slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] count_r, count_nxt;

  assign full      = (count_r == NW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_word = slot_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + NW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue slots hold payload only.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_word;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue pushed while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("queue popped while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NW'(DEPTH)) else $error("queue count beyond depth");

endmodule

`default_nettype wire

>>> hdl/mmab_front.sv
// Front end of the binarizer: accepts words, tracks frame state, min, max
// and threshold, and issues store commands. Depends on mmab_pkg.
`default_nettype none

module mmab_front
  import mmab_pkg::*;
#(
  parameter int MAX_PIXELS = MAX_PIXELS_DEF,
  parameter int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          in_kind,
  input  wire logic [7:0]    in_gray_pixel,
  input  wire logic          in_frame_end,
  input  wire logic          q_full,
  output logic               busy,
  output logic               push,
  output logic [AW-1:0]      push_addr,
  output cmd_t               push_cmd
);

  localparam int CW = $clog2(MAX_PIXELS + 1);

  logic          accept;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic [7:0]    lo_r, lo_nxt;
  logic [7:0]    hi_r, hi_nxt;
  logic [7:0]    thr_r, thr_nxt;
  logic          ready_r, ready_nxt;
  logic          pend_r, pend_nxt;
  logic [8:0]    sum;
  logic [16:0]   prod;

  // The threshold is computed in the cycle after the frame's last pixel.
  assign busy   = pend_r | q_full;
  assign accept = start & ~busy;

  // Threshold = min + floor((min + max) / 5), by reciprocal multiply.
  assign sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign prod = 17'(sum) * 17'(DIV5_MUL);

  // Classify the accepted word and update the frame state.
  always_comb begin
    logic [CW-1:0] base_count;
    logic [7:0]    base_lo;
    logic [7:0]    base_hi;
    base_count = ready_r ? '0 : count_r;
    base_lo    = ready_r ? 8'hFF : lo_r;
    base_hi    = ready_r ? 8'h00 : hi_r;

    count_nxt  = count_r;
    rd_idx_nxt = rd_idx_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    ready_nxt  = ready_r;
    pend_nxt   = 1'b0;
    thr_nxt    = pend_r ? (lo_r + {1'b0, prod[16:DIV5_SHIFT]}) : thr_r;
    push       = 1'b0;
    push_addr  = '0;
    push_cmd   = '{op: OP_WRITE, data: in_gray_pixel, last_mark: 1'b0};

    if (accept) begin
      if (in_kind == KIND_LOAD) begin
        // A load after a finished frame opens a new one.
        count_nxt  = base_count;
        lo_nxt     = base_lo;
        hi_nxt     = base_hi;
        ready_nxt  = 1'b0;
        if (ready_r) begin
          rd_idx_nxt = '0;
        end
        if (base_count < CW'(MAX_PIXELS)) begin
          push      = 1'b1;
          push_addr = base_count[AW-1:0];
          count_nxt = base_count + CW'(1);
          lo_nxt    = (in_gray_pixel < base_lo) ? in_gray_pixel : base_lo;
          hi_nxt    = (in_gray_pixel > base_hi) ? in_gray_pixel : base_hi;
        end
        if (in_frame_end) begin
          rd_idx_nxt = '0;
          ready_nxt  = 1'b1;
          pend_nxt   = 1'b1;
        end
      end else if (ready_r && (rd_idx_r < count_r)) begin
        // Drain the next stored pixel of a finished frame.
        push       = 1'b1;
        push_addr  = rd_idx_r[AW-1:0];
        push_cmd   = '{op: OP_READ, data: thr_r,
                       last_mark: ((rd_idx_r + CW'(1)) == count_r)};
        rd_idx_nxt = rd_idx_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      rd_idx_r <= '0;
      lo_r     <= 8'hFF;
      hi_r     <= 8'h00;
      thr_r    <= 8'h00;
      ready_r  <= 1'b0;
      pend_r   <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      rd_idx_r <= rd_idx_nxt;
      lo_r     <= lo_nxt;
      hi_r     <= hi_nxt;
      thr_r    <= thr_nxt;
      ready_r  <= ready_nxt;
      pend_r   <= pend_nxt;
    end
  end

  a_pend_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |=> !pend_r) else $error("threshold cycle lasted too long");
  a_frame_end_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_kind == KIND_LOAD && in_frame_end) |=> (pend_r && ready_r))
    else $error("frame end did not schedule the threshold");
  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_idx_r <= count_r) else $error("read index passed pixel count");

endmodule

`default_nettype wire

>>> hdl/mmab_back.sv
// Back end of the binarizer: frame store memory, writes and reads it in
// queue order and forms the binary result word. Depends on mmab_pkg.
`default_nettype none

module mmab_back
  import mmab_pkg::*;
#(
  parameter int MAX_PIXELS = MAX_PIXELS_DEF,
  parameter int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_valid,
  input  wire logic [AW-1:0] cmd_addr,
  input  wire cmd_t          cmd,
  output logic               out_valid,
  output logic [7:0]         out_binary_pixel,
  output logic [7:0]         out_frame_threshold,
  output logic               out_final_pixel
);

  logic [7:0] frame_mem [MAX_PIXELS];
  logic [7:0] rd_data_r;
  logic [7:0] thr_r;
  logic       last_r;
  logic       valid_r;
  logic       rd_issue;

  assign rd_issue = cmd_valid && (cmd.op == OP_READ);

  // Frame store: one write or one read per cycle, read data registered.
  always_ff @(posedge clk) begin
    if (cmd_valid && (cmd.op == OP_WRITE)) begin
      frame_mem[cmd_addr] <= cmd.data;
    end
    if (rd_issue) begin
      rd_data_r <= frame_mem[cmd_addr];
      thr_r     <= cmd.data;
      last_r    <= cmd.last_mark;
    end
  end

  // The result strobe is registered, so it rises in the cycle after a read is issued.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= rd_issue;
    end
  end

  assign out_valid           = valid_r;
  assign out_binary_pixel    = (rd_data_r > thr_r) ? 8'hFF : 8'h00;
  assign out_frame_threshold = thr_r;
  assign out_final_pixel     = last_r;

  a_read_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    rd_issue |=> out_valid) else $error("read gave no result strobe");
  a_no_stray_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (!rd_issue) |=> !out_valid) else $error("result strobe without a read");

endmodule

`default_nettype wire

>>> hdl/minmax_adaptive_binarizer.sv
// Channel   Handshake        Word
// input     start / busy     in_kind, in_gray_pixel, in_frame_end
// result    out_valid        out_binary_pixel, out_frame_threshold, out_final_pixel
//
// One input word is taken per clock while busy is low; the result of a drain
// passes through the queue and the registered frame store read before it is
// on the result ports. In the cycle after the word that ends a frame, busy is
// high while the threshold multiply-add runs.
// Reset is synchronous and active low; the frame store is not cleared.
// The receiver cannot stall; every out_valid cycle carries one result word.
// Top level; depends on mmab_pkg, mmab_front, mmab_fifo and mmab_back.
`default_nettype none

module minmax_adaptive_binarizer
  import mmab_pkg::*;
#(
  parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       in_kind,
  input  wire logic [7:0] in_gray_pixel,
  input  wire logic       in_frame_end,
  output logic            out_valid,
  output logic [7:0]      out_binary_pixel,
  output logic [7:0]      out_frame_threshold,
  output logic            out_final_pixel
);

  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int QW = AW + $bits(cmd_t);

  logic          q_full;
  logic          q_not_empty;
  logic          push;
  logic [AW-1:0] push_addr;
  cmd_t          push_cmd;
  logic [QW-1:0] head_word;
  logic [AW-1:0] head_addr;
  cmd_t          head_cmd;

  // Front end: classification and frame bookkeeping.
  mmab_front #(
    .MAX_PIXELS(MAX_PIXELS),
    .AW        (AW)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_kind      (in_kind),
    .in_gray_pixel(in_gray_pixel),
    .in_frame_end (in_frame_end),
    .q_full       (q_full),
    .busy         (busy),
    .push         (push),
    .push_addr    (push_addr),
    .push_cmd     (push_cmd)
  );

  // Command queue; the back end pops whenever a word is waiting.
  mmab_fifo #(
    .W    (QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_word({push_addr, push_cmd}),
    .pop      (q_not_empty),
    .full     (q_full),
    .not_empty(q_not_empty),
    .head_word(head_word)
  );

  assign head_addr = head_word[QW-1:$bits(cmd_t)];
  assign head_cmd  = cmd_t'(head_word[$bits(cmd_t)-1:0]);

  // Back end: frame store and result forming.
  mmab_back #(
    .MAX_PIXELS(MAX_PIXELS),
    .AW        (AW)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_valid          (q_not_empty),
    .cmd_addr           (head_addr),
    .cmd                (head_cmd),
    .out_valid          (out_valid),
    .out_binary_pixel   (out_binary_pixel),
    .out_frame_threshold(out_frame_threshold),
    .out_final_pixel    (out_final_pixel)
  );

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the min/max adaptive binarizer: random and directed pixel
// frames and drains, each result checked against a cycle-free predictor of the block.
// Depends on mmab_pkg and minmax_adaptive_binarizer.
`default_nettype none

module tb_top;
  import mmab_pkg::*;

  localparam int CAPACITY    = MAX_PIXELS_DEF;
  localparam int RANDOM_WORDS = 1950;
  localparam int MAX_REPORTS = 100;

  // One input word and one result word, field by field.
  typedef struct packed {
    logic       kind;
    logic [7:0] gray;
    logic       frame_end;
  } pix_word_t;

  typedef struct packed {
    logic [7:0] binary;
    logic [7:0] threshold;
    logic       final_mark;
  } bin_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic       in_kind = KIND_LOAD;
  logic [7:0] in_gray_pixel = 8'h00;
  logic       in_frame_end = 1'b0;
  logic       out_valid;
  logic [7:0] out_binary_pixel;
  logic [7:0] out_frame_threshold;
  logic       out_final_pixel;

  minmax_adaptive_binarizer #(
    .MAX_PIXELS(CAPACITY)
  ) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_kind            (in_kind),
    .in_gray_pixel      (in_gray_pixel),
    .in_frame_end       (in_frame_end),
    .out_valid          (out_valid),
    .out_binary_pixel   (out_binary_pixel),
    .out_frame_threshold(out_frame_threshold),
    .out_final_pixel    (out_final_pixel)
  );

  // Words waiting to be sent and binarized pixels waiting to come out.
  pix_word_t word_queue[$];
  bin_word_t bins_due[$];
  int        mismatch_count = 0;

  // Predictor copy of the frame and its statistics.
  logic [7:0]  frame_copy[CAPACITY];
  int unsigned stored_count = 0;
  int unsigned drain_pos = 0;
  logic [7:0]  gray_low = 8'hFF;
  logic [7:0]  gray_high = 8'h00;
  logic [7:0]  frame_thr = 8'h00;
  logic        frame_done = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Update the frame statistics for one accepted word and queue its binarized pixel.
  function automatic void binarize_word(input pix_word_t w);
    bin_word_t   r;
    int unsigned sum;
    logic [31:0] thr_wide;
    if (w.kind == KIND_LOAD) begin
      // A load after a finished frame opens a new one.
      if (frame_done) begin
        stored_count = 0;
        drain_pos    = 0;
        gray_low     = 8'hFF;
        gray_high    = 8'h00;
        frame_done   = 1'b0;
      end
      // Pixels past capacity are dropped but their end mark still counts.
      if (stored_count < CAPACITY) begin
        frame_copy[stored_count] = w.gray;
        stored_count++;
        if (w.gray > gray_high) gray_high = w.gray;
        if (w.gray < gray_low) gray_low = w.gray;
      end
      if (w.frame_end) begin
        sum        = gray_low + gray_high;
        thr_wide   = gray_low + sum / 5;
        frame_thr  = thr_wide[7:0];
        drain_pos  = 0;
        frame_done = 1'b1;
      end
    end else if (frame_done && drain_pos < stored_count) begin
      r.binary     = (frame_copy[drain_pos] > frame_thr) ? 8'hFF : 8'h00;
      r.threshold  = frame_thr;
      r.final_mark = (drain_pos + 1 == stored_count);
      drain_pos++;
      bins_due.insert(bins_due.size(), r);
    end
  endfunction

  // Sender: bursts of words separated by random gaps.
  int        burst_left = 1;
  int        gap_left = 0;
  pix_word_t cur_word;

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) binarize_word(cur_word);
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (word_queue.size() > 0) begin
          cur_word = word_queue.pop_front();
          in_kind       <= cur_word.kind;
          in_gray_pixel <= cur_word.gray;
          in_frame_end  <= cur_word.frame_end;
          start         <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 12);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Compare one field and report it if it differs.
  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      if (mismatch_count < MAX_REPORTS)
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Receiver: every strobed word is matched against the oldest expectation.
  bin_word_t want_bin;

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (bins_due.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("%0t: result word expected none actual %0d/%0d/%0d", $time,
                   out_binary_pixel, out_frame_threshold, out_final_pixel);
        mismatch_count++;
      end else begin
        want_bin = bins_due.pop_front();
        check_field("binary_pixel", want_bin.binary, out_binary_pixel);
        check_field("frame_threshold", want_bin.threshold, out_frame_threshold);
        check_field("final_pixel", want_bin.final_mark, out_final_pixel);
      end
    end
  end

  // Stimulus helpers.
  function automatic void push_load(input logic [7:0] gray, input logic last);
    pix_word_t w;
    w.kind      = KIND_LOAD;
    w.gray      = gray;
    w.frame_end = last;
    word_queue.insert(word_queue.size(), w);
  endfunction

  // Drain words carry random values in the fields that the block ignores.
  function automatic void push_drain(input int count);
    pix_word_t w;
    for (int i = 0; i < count; i++) begin
      w.kind      = KIND_DRAIN;
      w.gray      = 8'($urandom_range(0, 255));
      w.frame_end = 1'($urandom_range(0, 1));
      word_queue.insert(word_queue.size(), w);
    end
  endfunction

  // Pick a gray level for one of the content styles of a random frame.
  function automatic logic [7:0] pick_gray(input int style, input int base);
    int g;
    case (style)
      0: begin
        g = $urandom_range(0, 255);
      end
      1: begin
        g = base + $urandom_range(0, 15);
        if (g > 255) g = 255;
      end
      2: begin
        g = $urandom_range(180, 255);
      end
      default: begin
        g = ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(0, 60);
      end
    endcase
    return g[7:0];
  endfunction

  int useful_words = 0;
  int n_pix;
  int style;
  int base;
  int n_drain;
  int pick;

  initial begin
    // Drain straight after reset: nothing pending.
    push_drain(1);
    // Drain while a frame is still loading, then a two-pixel frame at both extremes.
    push_load(8'h00, 1'b0);
    push_drain(1);
    push_load(8'hFF, 1'b1);
    // Both pixels, then a drain past the end of the run.
    push_drain(3);
    // Single bright pixel: the threshold wraps past 255.
    push_load(8'hFF, 1'b1);
    push_drain(1);
    // Flat frame drained only partly, then replaced by a new frame.
    push_load(8'd100, 1'b0);
    push_load(8'd100, 1'b1);
    push_drain(1);
    push_load(8'd7, 1'b0);
    push_load(8'd200, 1'b0);
    push_load(8'd0, 1'b1);
    push_drain(4);
    // Single dark pixel: threshold of zero, pixel not above it.
    push_load(8'h00, 1'b1);
    push_drain(2);

    // Random frames of assorted content and length.
    while (useful_words < RANDOM_WORDS) begin
      n_pix = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
      style = $urandom_range(0, 3);
      base  = $urandom_range(0, 255);
      for (int i = 0; i < n_pix; i++) begin
        // Occasional stray drain inside an unfinished frame.
        if (i > 0 && $urandom_range(0, 9) == 0) push_drain(1);
        push_load(pick_gray(style, base), i == n_pix - 1);
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) n_drain = n_pix + $urandom_range(0, 2);
      else if (pick < 9) n_drain = $urandom_range(0, n_pix - 1);
      else n_drain = 0;
      push_drain(n_drain);
      useful_words += n_pix + ((n_drain < n_pix) ? n_drain : n_pix);
    end
  end

  // End of run: all words sent, all results in, then a short settle.
  initial begin
    wait (rst_n);
    while (word_queue.size() != 0 || start) @(posedge clk);
    for (int k = 0; k < 64 && bins_due.size() != 0; k++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (bins_due.size() != 0) begin
      $display("%0t: %0d result words expected but never seen", $time, bins_due.size());
      mismatch_count += bins_due.size();
    end
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
hdl/mmab_pkg.sv
hdl/mmab_fifo.sv
hdl/mmab_front.sv
hdl/mmab_back.sv
hdl/minmax_adaptive_binarizer.sv
tb/tb_top.sv
